// File: rtl/core/cdt_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer package
// Types, command codes, state codes and constants shared by the countdown
// timer modules.
// ----------------------------------------------------------------------------
package cdt_pkg;

   localparam int EFFECT_KINDS = 4;

   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_PAUSE  = 3'd1;
   localparam logic [2:0] OP_RESUME = 3'd2;
   localparam logic [2:0] OP_RESET  = 3'd3;
   localparam logic [2:0] OP_STOP   = 3'd4;
   localparam logic [2:0] OP_REPEAT = 3'd5;
   localparam logic [2:0] OP_POLL   = 3'd6;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_RUNNING = 2'd1;
   localparam logic [1:0] ST_PAUSED  = 2'd2;
   localparam logic [1:0] ST_FIRED   = 2'd3;

   localparam logic [9:0]  MS_PER_SEC = 10'd1000;
   localparam logic [31:0] LEFT_MAX   = 32'd65535000;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] duration_sec;
      logic [1:0]  effect_code;
      logic [31:0] now_ms;
   } cdt_req_type;

   typedef struct packed {
      logic [1:0]  timer_state;
      logic [25:0] remaining_ms;
      logic [31:0] end_tick;
      logic [15:0] duration_out;
      logic [1:0]  effect_out;
      logic        timeout_valid;
      logic [31:0] timeout_ms;
      logic        fired_pulse;
   } cdt_rsp_type;

   typedef struct packed {
      logic [1:0]  run_state;
      logic [25:0] left_ms;
      logic [31:0] expiry_tick;
      logic [15:0] loaded_seconds;
      logic [1:0]  effect_tag;
   } cdt_state_type;

endpackage

// File: rtl/core/countdown_timer_pause_resume.sv
// ----------------------------------------------------------------------------
// Countdown timer with pause and resume
// Millisecond countdown timer driven by one command per request.
// ----------------------------------------------------------------------------
// The timer takes one command per clock cycle while req_stall is low and
// answers each with exactly one response: a request is held in the request
// register and then in the response register, with the state update done
// between them. When the response side stalls, one further request is
// still taken into the request register before the request side stalls.
module countdown_timer_pause_resume (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cdt_pkg::cdt_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cdt_pkg::cdt_rsp_type rsp_data
);
   import cdt_pkg::*;

   logic          req_valid_ff;
   logic          req_valid_in;
   cdt_req_type   req_data_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   cdt_rsp_type   rsp_data_ff;
   cdt_state_type state_ff;
   cdt_state_type state_in;
   cdt_rsp_type   step_rsp;
   logic          out_free;
   logic          advance;
   logic          req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   cdt_step u_step (
      .req (req_data_ff),
      .cur (state_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/cdt_step.sv
// ----------------------------------------------------------------------------
// Countdown timer command step
// Computes the next timer state and the response for one request from the
// current state.
// ----------------------------------------------------------------------------
module cdt_step (
   input  cdt_pkg::cdt_req_type   req,
   input  cdt_pkg::cdt_state_type cur,
   output cdt_pkg::cdt_state_type nxt,
   output cdt_pkg::cdt_rsp_type   rsp
);
   import cdt_pkg::*;

   logic [1:0]  eff;
   logic [25:0] start_ms;
   logic [25:0] reload_ms;
   logic [31:0] to_end;
   logic [31:0] past_end;
   logic [25:0] pause_ms;
   logic        tvalid;
   logic [31:0] tms;
   logic        pulse;

   assign eff       = (32'(req.effect_code) >= 32'(EFFECT_KINDS)) ? 2'd0 : req.effect_code;
   assign start_ms  = 26'(req.duration_sec * MS_PER_SEC);
   assign reload_ms = 26'(cur.loaded_seconds * MS_PER_SEC);
   assign to_end    = cur.expiry_tick - req.now_ms;
   assign past_end  = req.now_ms - cur.expiry_tick;

   always_comb begin
      if (to_end == 32'd0 || to_end[31]) begin
         pause_ms = 26'd0;
      end else if (to_end > LEFT_MAX) begin
         pause_ms = LEFT_MAX[25:0];
      end else begin
         pause_ms = to_end[25:0];
      end
   end

   always_comb begin
      nxt    = cur;
      tvalid = 1'b0;
      tms    = 32'd0;
      pulse  = 1'b0;
      case (req.opcode)
         OP_START: begin
            nxt.loaded_seconds = req.duration_sec;
            nxt.effect_tag     = eff;
            nxt.left_ms        = start_ms;
            nxt.expiry_tick    = req.now_ms + 32'(start_ms);
            nxt.run_state      = ST_RUNNING;
         end
         OP_PAUSE: begin
            if (cur.run_state == ST_RUNNING) begin
               nxt.left_ms   = pause_ms;
               nxt.run_state = ST_PAUSED;
            end
         end
         OP_RESUME: begin
            if (cur.run_state == ST_PAUSED) begin
               nxt.expiry_tick = req.now_ms + 32'(cur.left_ms);
               nxt.run_state   = ST_RUNNING;
            end
         end
         OP_RESET: begin
            nxt.left_ms = reload_ms;
            if (cur.run_state == ST_RUNNING) begin
               nxt.expiry_tick = req.now_ms + 32'(reload_ms);
            end
         end
         OP_STOP: begin
            nxt.run_state = ST_IDLE;
            nxt.left_ms   = 26'd0;
         end
         OP_REPEAT: begin
            nxt.left_ms   = reload_ms;
            nxt.run_state = ST_PAUSED;
         end
         OP_POLL: begin
            if (cur.run_state == ST_RUNNING) begin
               if (!past_end[31]) begin
                  nxt.run_state = ST_FIRED;
                  nxt.left_ms   = 26'd0;
                  pulse         = 1'b1;
               end else begin
                  tvalid = 1'b1;
                  tms    = to_end;
               end
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   always_comb begin
      rsp.timer_state   = nxt.run_state;
      rsp.remaining_ms  = nxt.left_ms;
      rsp.end_tick      = nxt.expiry_tick;
      rsp.duration_out  = nxt.loaded_seconds;
      rsp.effect_out    = nxt.effect_tag;
      rsp.timeout_valid = tvalid;
      rsp.timeout_ms    = tms;
      rsp.fired_pulse   = pulse;
   end

endmodule

// File: tb/sv/countdown_timer_pause_resume_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Countdown timer testbench
// Sends timer commands through the request channel and checks every response
// field against a cycle-free model of the timer kept inside the testbench.
// A short directed list covers the idle, wrap, clamp and expiry corners, and
// random command sequences follow, with random idling on both sides, a long
// response hold-off and a full drain of the pipeline.
// ----------------------------------------------------------------------------
module countdown_timer_pause_resume_tb;
   import cdt_pkg::*;

   localparam int RANDOM_ITEMS   = 1400;
   localparam int HOLD_AT        = 400;
   localparam int HOLD_LEN       = 64;
   localparam int DRAIN_AT       = 700;
   localparam int QUIET_FROM     = 900;
   localparam int QUIET_TO       = 1150;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [2:0] OP_SPARE = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cdt_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   cdt_rsp_type rsp_data;

   cdt_req_type   pending_cmds[$];
   cdt_rsp_type   expected_rsps[$];
   cdt_state_type timer_model = '0;
   int            sent_count = 0;
   int            rsp_count = 0;
   int            error_count = 0;
   int            hold_left = 0;
   int            idle_cycles = 0;
   bit            draining = 1'b0;
   logic [31:0]   wall_ms = 32'hFFF0_0000;

   countdown_timer_pause_resume u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic cdt_rsp_type timer_predict(input cdt_req_type cmd);
      cdt_rsp_type rsp;
      logic [31:0] gap;
      logic [1:0]  eff;
      logic [25:0] full_ms;
      rsp = '0;
      eff = (int'(cmd.effect_code) >= EFFECT_KINDS) ? 2'd0 : cmd.effect_code;
      full_ms = 26'(32'(timer_model.loaded_seconds) * 32'(MS_PER_SEC));
      case (cmd.opcode)
         OP_START: begin
            timer_model.loaded_seconds = cmd.duration_sec;
            timer_model.effect_tag = eff;
            timer_model.left_ms = 26'(32'(cmd.duration_sec) * 32'(MS_PER_SEC));
            timer_model.expiry_tick = cmd.now_ms + 32'(timer_model.left_ms);
            timer_model.run_state = ST_RUNNING;
         end
         OP_PAUSE: begin
            if (timer_model.run_state == ST_RUNNING) begin
               gap = timer_model.expiry_tick - cmd.now_ms;
               if (gap == 32'd0 || gap[31]) begin
                  timer_model.left_ms = '0;
               end else if (gap > LEFT_MAX) begin
                  timer_model.left_ms = 26'(LEFT_MAX);
               end else begin
                  timer_model.left_ms = 26'(gap);
               end
               timer_model.run_state = ST_PAUSED;
            end
         end
         OP_RESUME: begin
            if (timer_model.run_state == ST_PAUSED) begin
               timer_model.expiry_tick = cmd.now_ms + 32'(timer_model.left_ms);
               timer_model.run_state = ST_RUNNING;
            end
         end
         OP_RESET: begin
            timer_model.left_ms = full_ms;
            if (timer_model.run_state == ST_RUNNING) begin
               timer_model.expiry_tick = cmd.now_ms + 32'(full_ms);
            end
         end
         OP_STOP: begin
            timer_model.run_state = ST_IDLE;
            timer_model.left_ms = '0;
         end
         OP_REPEAT: begin
            timer_model.left_ms = full_ms;
            timer_model.run_state = ST_PAUSED;
         end
         OP_POLL: begin
            if (timer_model.run_state == ST_RUNNING) begin
               gap = cmd.now_ms - timer_model.expiry_tick;
               if (!gap[31]) begin
                  timer_model.run_state = ST_FIRED;
                  timer_model.left_ms = '0;
                  rsp.fired_pulse = 1'b1;
               end else begin
                  rsp.timeout_valid = 1'b1;
                  rsp.timeout_ms = timer_model.expiry_tick - cmd.now_ms;
               end
            end
         end
         default: begin
         end
      endcase
      rsp.timer_state = timer_model.run_state;
      rsp.remaining_ms = timer_model.left_ms;
      rsp.end_tick = timer_model.expiry_tick;
      rsp.duration_out = timer_model.loaded_seconds;
      rsp.effect_out = timer_model.effect_tag;
      return rsp;
   endfunction

   task automatic queue_cmd(input logic [2:0] op, input logic [15:0] secs,
                            input logic [1:0] eff, input logic [31:0] now);
      cdt_req_type cmd;
      cmd.opcode = op;
      cmd.duration_sec = secs;
      cmd.effect_code = eff;
      cmd.now_ms = now;
      pending_cmds.insert(pending_cmds.size(), cmd);
   endtask

   task automatic advance_wall();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 68) begin
         wall_ms += $urandom_range(1500);
      end else if (pick < 85) begin
         wall_ms += $urandom_range(12000);
      end else if (pick < 92) begin
         wall_ms += $urandom_range(70000000);
      end else if (pick < 97) begin
         wall_ms -= $urandom_range(5000);
      end else begin
         wall_ms = $urandom;
      end
   endtask

   function automatic logic [15:0] pick_seconds();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70) return 16'($urandom_range(5));
      if (pick < 90) return 16'($urandom_range(60));
      if (pick < 98) return 16'($urandom);
      return 16'hFFFF;
   endfunction

   function automatic logic [2:0] pick_opcode();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 40) return OP_POLL;
      if (pick < 55) return OP_PAUSE;
      if (pick < 70) return OP_RESUME;
      if (pick < 80) return OP_RESET;
      if (pick < 87) return OP_REPEAT;
      if (pick < 92) return OP_STOP;
      if (pick < 97) return OP_START;
      return 3'($urandom_range(7));
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
         error_count++;
      end
   endtask

   initial begin
      int target;
      int steps;

      // Directed corners: commands in idle, an expiry tick that wraps,
      // a backwards tick that saturates the time left, exact expiry,
      // the signed half-range boundary of poll, and the unused opcode.
      queue_cmd(OP_POLL, 16'd0, 2'd0, 32'd0);
      queue_cmd(OP_PAUSE, 16'd0, 2'd0, 32'd0);
      queue_cmd(OP_RESUME, 16'd0, 2'd0, 32'd0);
      queue_cmd(OP_RESET, 16'd0, 2'd0, 32'd0);
      queue_cmd(OP_SPARE, 16'hFFFF, 2'd3, 32'hFFFF_FFFF);
      queue_cmd(OP_START, 16'hFFFF, 2'd3, 32'hFFFF_F000);
      queue_cmd(OP_POLL, 16'd0, 2'd0, 32'hFFFF_F001);
      queue_cmd(OP_PAUSE, 16'd0, 2'd0, 32'hFFFF_F000 - 32'd1000);
      queue_cmd(OP_RESUME, 16'd0, 2'd0, 32'd0);
      queue_cmd(OP_PAUSE, 16'd0, 2'd0, 32'd65535000);
      queue_cmd(OP_RESUME, 16'd0, 2'd0, 32'd100);
      queue_cmd(OP_POLL, 16'd0, 2'd0, 32'd100);
      queue_cmd(OP_POLL, 16'd0, 2'd0, 32'd200);
      queue_cmd(OP_RESET, 16'd7, 2'd1, 32'd300);
      queue_cmd(OP_REPEAT, 16'd0, 2'd0, 32'd400);
      queue_cmd(OP_RESUME, 16'd0, 2'd0, 32'h7FFF_FFFF);
      queue_cmd(OP_PAUSE, 16'd0, 2'd0, 32'hFFFF_FFFF);
      queue_cmd(OP_START, 16'd0, 2'd0, 32'd0);
      queue_cmd(OP_POLL, 16'd0, 2'd0, 32'h8000_0000);
      queue_cmd(OP_POLL, 16'd0, 2'd0, 32'h7FFF_FFFF);
      queue_cmd(OP_START, 16'd1, 2'd2, 32'd5000);
      queue_cmd(OP_RESET, 16'd0, 2'd0, 32'd5500);
      queue_cmd(OP_PAUSE, 16'd0, 2'd0, 32'd6000);
      queue_cmd(OP_STOP, 16'd0, 2'd0, 32'd6100);
      queue_cmd(OP_START, 16'd1, 2'd1, 32'd0);
      queue_cmd(OP_PAUSE, 16'd0, 2'd0, 32'd2000);

      target = pending_cmds.size() + RANDOM_ITEMS;
      while (pending_cmds.size() < target) begin
         if ($urandom_range(99) < 10) begin
            queue_cmd(3'($urandom_range(7)), 16'($urandom), 2'($urandom), $urandom);
         end else begin
            advance_wall();
            queue_cmd(OP_START, pick_seconds(), 2'($urandom), wall_ms);
            steps = $urandom_range(2, 10);
            repeat (steps) begin
               advance_wall();
               queue_cmd(pick_opcode(), pick_seconds(), 2'($urandom), wall_ms);
            end
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         timer_model = '0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.insert(expected_rsps.size(), timer_predict(req_data));
            sent_count++;
            if (sent_count == DRAIN_AT) draining = 1'b1;
         end
         if (draining && expected_rsps.size() == 0) draining = 1'b0;
         if (!req_valid || !req_stall) begin
            if (pending_cmds.size() == 0 || draining ||
                (!(sent_count >= QUIET_FROM && sent_count < QUIET_TO) &&
                 $urandom_range(99) < 9)) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data <= pending_cmds.pop_front();
            end
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      cdt_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding: 0x%h", rsp_data);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("timer_state", 32'(want.timer_state), 32'(rsp_data.timer_state));
               check_field("remaining_ms", 32'(want.remaining_ms),
                           32'(rsp_data.remaining_ms));
               check_field("end_tick", want.end_tick, rsp_data.end_tick);
               check_field("duration_out", 32'(want.duration_out),
                           32'(rsp_data.duration_out));
               check_field("effect_out", 32'(want.effect_out), 32'(rsp_data.effect_out));
               check_field("timeout_valid", 32'(want.timeout_valid),
                           32'(rsp_data.timeout_valid));
               check_field("timeout_ms", want.timeout_ms, rsp_data.timeout_ms);
               check_field("fired_pulse", 32'(want.fired_pulse), 32'(rsp_data.fired_pulse));
            end
            if (rsp_count == HOLD_AT) hold_left <= HOLD_LEN;
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (rsp_count == HOLD_AT && rsp_valid && !rsp_stall) begin
            rsp_stall <= 1'b1;
         end else if (rsp_count >= QUIET_FROM && rsp_count < QUIET_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 9);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
